// File: sv/zigzag_scan_reorder_top_defines.svh
// ---------------------------------------------------------------------------
// Zigzag scan reorder - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ZIGZAG_SCAN_REORDER_TOP_DEFINES_SVH
`define ZIGZAG_SCAN_REORDER_TOP_DEFINES_SVH

// same-cycle implication
`define ZSR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ZSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/zsr_pkg.sv
// ---------------------------------------------------------------------------
// Zigzag scan reorder - package
// Shared constants, request codes and the control struct.
// ---------------------------------------------------------------------------
package zsr_pkg;

	localparam int DEF_MAX_SIDE  = 64;
	localparam int DEF_DATA_BITS = 16;

	localparam int              SIZE_W     = 7;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd8;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} zsr_ctl_t;

endpackage

// File: sv/zsr_if.sv
// ---------------------------------------------------------------------------
// Zigzag scan reorder - channel interfaces
// Request channel (write or read) and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface zsr_req_if import zsr_pkg::*; #(
	parameter int DATA_BITS = DEF_DATA_BITS
) ();
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [DATA_BITS-1:0] element_value;

	modport source (output valid, output req_type, output element_value, input ready);
	modport sink   (input valid, input req_type, input element_value, output ready);
endinterface

interface zsr_rsp_if import zsr_pkg::*; #(
	parameter int DATA_BITS = DEF_DATA_BITS,
	parameter int IDX_W     = $clog2(DEF_MAX_SIDE)
) ();
	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] out_value;
	logic [IDX_W-1:0]     out_row;
	logic [IDX_W-1:0]     out_col;
	logic                 is_last;

	modport source (output valid, output out_value, output out_row, output out_col,
		output is_last, input ready);
	modport sink   (input valid, input out_value, input out_row, input out_col,
		input is_last, output ready);
endinterface

// File: sv/zsr_walk.sv
// ---------------------------------------------------------------------------
// Zigzag scan reorder - position walker
// Holds the row-major load position and the zigzag scan position; an accepted
// write advances the load position and an accepted read the scan position.
// ---------------------------------------------------------------------------
module zsr_walk import zsr_pkg::*; #(
	parameter int MAX_SIDE = DEF_MAX_SIDE,
	parameter int IDX_W    = $clog2(MAX_SIDE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  logic              step,
	input  logic              req_type,
	output zsr_ctl_t          ctl,
	output logic [IDX_W-1:0]  ld_row,
	output logic [IDX_W-1:0]  ld_col,
	output logic [IDX_W-1:0]  sc_row,
	output logic [IDX_W-1:0]  sc_col,
	output logic              sc_last
);

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CMP_W  = (SIZE_W > SIDE_W) ? SIZE_W : SIDE_W;

	typedef enum logic [1:0] {
		DIR_UP_RIGHT,
		DIR_RIGHT,
		DIR_DOWN_LEFT
	} dir_t;

	logic [SIZE_W-1:0] size_q;
	logic [IDX_W-1:0]  ld_row_q, ld_col_q, sc_row_q, sc_col_q;
	dir_t              dir_q;

	logic [CMP_W-1:0]  size_ext;
	logic [SIDE_W-1:0] side_n, side_m1;
	logic              ld_col_end, ld_row_end;
	logic              sc_col_end, sc_row_end, sc_row_top, sc_col_left;
	logic [IDX_W-1:0]  sc_row_nx, sc_col_nx;
	dir_t              dir_nx;

	// effective side: zero acts as one, clamp to MAX_SIDE
	assign size_ext = CMP_W'(size_q);
	always_comb begin
		if (size_q == '0) begin
			side_n = SIDE_W'(1);
		end else if (size_ext > CMP_W'(MAX_SIDE)) begin
			side_n = SIDE_W'(MAX_SIDE);
		end else begin
			side_n = SIDE_W'(size_ext);
		end
	end
	assign side_m1 = side_n - SIDE_W'(1);

	assign ld_col_end  = (SIDE_W'(ld_col_q) == side_m1);
	assign ld_row_end  = (SIDE_W'(ld_row_q) == side_m1);
	assign sc_col_end  = (SIDE_W'(sc_col_q) == side_m1);
	assign sc_row_end  = (SIDE_W'(sc_row_q) == side_m1);
	assign sc_row_top  = (sc_row_q == '0);
	assign sc_col_left = (sc_col_q == '0);

	always_comb begin
		sc_row_nx = sc_row_q;
		sc_col_nx = sc_col_q;
		dir_nx    = dir_q;
		if (sc_row_end && sc_col_end) begin
			sc_row_nx = '0;
			sc_col_nx = '0;
			dir_nx    = DIR_RIGHT;
		end else begin
			case (dir_q)
				DIR_UP_RIGHT: begin
					if (sc_col_end) begin
						sc_row_nx = sc_row_q + IDX_W'(1);
						dir_nx    = DIR_DOWN_LEFT;
					end else if (sc_row_top) begin
						sc_col_nx = sc_col_q + IDX_W'(1);
						dir_nx    = DIR_DOWN_LEFT;
					end else begin
						sc_row_nx = sc_row_q - IDX_W'(1);
						sc_col_nx = sc_col_q + IDX_W'(1);
					end
				end
				DIR_DOWN_LEFT: begin
					if (sc_row_end) begin
						sc_col_nx = sc_col_q + IDX_W'(1);
						dir_nx    = DIR_UP_RIGHT;
					end else if (sc_col_left) begin
						sc_row_nx = sc_row_q + IDX_W'(1);
						dir_nx    = DIR_UP_RIGHT;
					end else begin
						sc_row_nx = sc_row_q + IDX_W'(1);
						sc_col_nx = sc_col_q - IDX_W'(1);
					end
				end
				default: begin
					if (sc_col_end) begin
						sc_row_nx = sc_row_q + IDX_W'(1);
						dir_nx    = DIR_DOWN_LEFT;
					end else begin
						sc_col_nx = sc_col_q + IDX_W'(1);
						dir_nx    = sc_row_top ? DIR_DOWN_LEFT : DIR_UP_RIGHT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SIZE_RESET;
			ld_row_q <= '0;
			ld_col_q <= '0;
			sc_row_q <= '0;
			sc_col_q <= '0;
			dir_q    <= DIR_RIGHT;
		end else if (cfg_we) begin
			// new size restarts both load and scan
			size_q   <= cfg_wdata;
			ld_row_q <= '0;
			ld_col_q <= '0;
			sc_row_q <= '0;
			sc_col_q <= '0;
			dir_q    <= DIR_RIGHT;
		end else if (step) begin
			if (req_type == REQ_WRITE) begin
				if (ld_col_end) begin
					ld_col_q <= '0;
					ld_row_q <= ld_row_end ? '0 : ld_row_q + IDX_W'(1);
				end else begin
					ld_col_q <= ld_col_q + IDX_W'(1);
				end
			end else begin
				sc_row_q <= sc_row_nx;
				sc_col_q <= sc_col_nx;
				dir_q    <= dir_nx;
			end
		end
	end

	assign ctl.wr_en = step && (req_type == REQ_WRITE);
	assign ctl.rd_en = step && (req_type == REQ_READ);
	assign ld_row    = ld_row_q;
	assign ld_col    = ld_col_q;
	assign sc_row    = sc_row_q;
	assign sc_col    = sc_col_q;
	assign sc_last   = sc_row_end && sc_col_end;

endmodule

// File: sv/zsr_mem.sv
// ---------------------------------------------------------------------------
// Zigzag scan reorder - element store
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module zsr_mem import zsr_pkg::*; #(
	parameter int ADDR_W    = 12,
	parameter int DATA_BITS = DEF_DATA_BITS
) (
	input  logic                 clk,
	input  zsr_ctl_t             ctl,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic [ADDR_W-1:0]    rd_addr,
	output logic [DATA_BITS-1:0] rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_BITS-1:0] mem [DEPTH];
	logic [DATA_BITS-1:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data while the result is stalled
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_s1;

endmodule

// File: sv/zigzag_scan_reorder_top.sv
// ---------------------------------------------------------------------------
// Zigzag scan reorder - top level
// Stores an N x N matrix in row-major order and returns it in zigzag order.
// ---------------------------------------------------------------------------
// Usage:
//   req : request channel. req_type write stores element_value at the next
//         row-major position; req_type read asks for the next zigzag element.
//   rsp : one result per read request: value, row, column and is_last at the
//         bottom-right corner. Write requests give no result.
//   cfg_we/cfg_wdata set the side length N (0 acts as 1, clamped to MAX_SIDE)
//   and restart both load and scan positions at (0,0). Write it only when idle.
// Result: a read result is valid the cycle after its request is accepted.
// Throughput: one request per cycle unless a result stalls; separate write and
//   read ports, and the registered read data doubles as the output register.
// Reset: N returns to 8 and all positions to (0,0); the store is not cleared,
//   so read only elements that were written.
// Stall: while a result waits with rsp.ready low, req.ready drops and the
//   result holds.
// ---------------------------------------------------------------------------
`include "zigzag_scan_reorder_top_defines.svh"

module zigzag_scan_reorder_top import zsr_pkg::*; #(
	parameter int MAX_SIDE  = DEF_MAX_SIDE,
	parameter int DATA_BITS = DEF_DATA_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	zsr_req_if.sink           req,
	zsr_rsp_if.source         rsp
);

	localparam int IDX_W  = $clog2(MAX_SIDE);
	localparam int ADDR_W = 2 * IDX_W;

	zsr_ctl_t         ctl;
	logic             step;
	logic [IDX_W-1:0] ld_row, ld_col, sc_row, sc_col;
	logic             sc_last;

	logic             valid_s1;
	logic [IDX_W-1:0] row_s1, col_s1;
	logic             last_s1;

	assign req.ready = !valid_s1 || rsp.ready;
	assign step      = req.valid && req.ready;

	zsr_walk #(
		.MAX_SIDE (MAX_SIDE),
		.IDX_W    (IDX_W)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.req_type  (req.req_type),
		.ctl       (ctl),
		.ld_row    (ld_row),
		.ld_col    (ld_col),
		.sc_row    (sc_row),
		.sc_col    (sc_col),
		.sc_last   (sc_last)
	);

	zsr_mem #(
		.ADDR_W    (ADDR_W),
		.DATA_BITS (DATA_BITS)
	) u_mem (
		.clk     (clk),
		.ctl     (ctl),
		.wr_addr ({ld_row, ld_col}),
		.wr_data (req.element_value),
		.rd_addr ({sc_row, sc_col}),
		.rd_data (rsp.out_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.rd_en) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			row_s1  <= sc_row;
			col_s1  <= sc_col;
			last_s1 <= sc_last;
		end
	end

	assign rsp.valid   = valid_s1;
	assign rsp.out_row = row_s1;
	assign rsp.out_col = col_s1;
	assign rsp.is_last = last_s1;

	`ZSR_ASSERT_NEXT(a_read_gives_result, step && req.req_type == REQ_READ, rsp.valid, "read request gave no result")
	`ZSR_ASSERT_NEXT(a_write_gives_none, step && req.req_type == REQ_WRITE, !rsp.valid, "write request gave a result")
	`ZSR_ASSERT_NOW(a_last_on_diagonal, rsp.valid && rsp.is_last, rsp.out_row == rsp.out_col, "end of scan off the diagonal")

endmodule

// File: bench/tb_zigzag_scan_reorder_top.sv
// ---------------------------------------------------------------------------
// Zigzag scan reorder - testbench
// Loads matrices of several side lengths, reads them back in zigzag order under
// random stalls on both channels, and checks every result against a tracked
// copy of the store, the load position and the zigzag walk.
// ---------------------------------------------------------------------------
module tb_zigzag_scan_reorder_top;
	import zsr_pkg::*;

	localparam int SIDE_MAX     = DEF_MAX_SIDE;
	localparam int TOTAL_ITEMS  = 1850;
	localparam int PHASE_ITEMS  = 110;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int NUM_PHASES   = 14;

	typedef enum logic [1:0] {
		WALK_UP_RIGHT,
		WALK_RIGHT,
		WALK_DOWN_LEFT
	} walk_dir_t;

	typedef struct packed {
		logic [15:0] value;
		logic [5:0]  row;
		logic [5:0]  col;
		logic        last;
	} zz_element_t;

	class zigzag_scan_tracker;
		logic [15:0]  store [0:SIDE_MAX*SIDE_MAX-1];
		bit           written [0:SIDE_MAX*SIDE_MAX-1];
		int           load_row, load_col;
		int           scan_row, scan_col;
		walk_dir_t    scan_dir;
		logic [6:0]   side_reg;
		zz_element_t  pending_elements [$];
		int           errors;

		function new();
			side_reg = SIZE_RESET;
			errors   = 0;
			restart();
		endfunction

		function void restart();
			load_row = 0;
			load_col = 0;
			scan_row = 0;
			scan_col = 0;
			scan_dir = WALK_RIGHT;
		endfunction

		function int side();
			if (side_reg < 1)
				return 1;
			if (side_reg > SIDE_MAX)
				return SIDE_MAX;
			return int'(side_reg);
		endfunction

		function void set_size(logic [6:0] v);
			side_reg = v;
			restart();
		endfunction

		function int pending();
			return pending_elements.size();
		endfunction

		function void normalize(int n);
			if (load_row >= n || load_col >= n) begin
				load_row = 0;
				load_col = 0;
			end
			if (scan_row >= n || scan_col >= n) begin
				scan_row = 0;
				scan_col = 0;
				scan_dir = WALK_RIGHT;
			end
		endfunction

		// a read is legal only where the current zigzag entry has been loaded
		function bit can_read();
			int n;
			n = side();
			if (scan_row >= n || scan_col >= n)
				return written[0];
			return written[scan_row*SIDE_MAX + scan_col];
		endfunction

		function void advance(int n);
			int r, c;
			r = scan_row;
			c = scan_col;
			case (scan_dir)
				WALK_UP_RIGHT: begin
					if (c + 1 == n) begin
						r++;
						scan_dir = WALK_DOWN_LEFT;
					end else if (r == 0) begin
						c++;
						scan_dir = WALK_DOWN_LEFT;
					end else begin
						r--;
						c++;
					end
				end
				WALK_DOWN_LEFT: begin
					if (r + 1 == n) begin
						c++;
						scan_dir = WALK_UP_RIGHT;
					end else if (c == 0) begin
						r++;
						scan_dir = WALK_UP_RIGHT;
					end else begin
						r++;
						c--;
					end
				end
				default: begin
					if (c + 1 == n) begin
						r++;
						scan_dir = WALK_DOWN_LEFT;
					end else begin
						c++;
						scan_dir = (r == 0) ? WALK_DOWN_LEFT : WALK_UP_RIGHT;
					end
				end
			endcase
			if (r >= n || c >= n) begin
				r = 0;
				c = 0;
				scan_dir = WALK_RIGHT;
			end
			scan_row = r;
			scan_col = c;
		endfunction

		function void note_request(logic kind, logic [15:0] value);
			int          n;
			int          k;
			zz_element_t e;
			n = side();
			normalize(n);
			if (kind == REQ_WRITE) begin
				k = load_row*SIDE_MAX + load_col;
				store[k]   = value;
				written[k] = 1'b1;
				load_col++;
				if (load_col >= n) begin
					load_col = 0;
					load_row++;
					if (load_row >= n)
						load_row = 0;
				end
			end else begin
				e.value = store[scan_row*SIDE_MAX + scan_col];
				e.row   = scan_row[5:0];
				e.col   = scan_col[5:0];
				e.last  = (scan_row == n - 1) && (scan_col == n - 1);
				pending_elements.push_back(e);
				if (e.last) begin
					scan_row = 0;
					scan_col = 0;
					scan_dir = WALK_RIGHT;
				end else begin
					advance(n);
				end
			end
		endfunction

		function void check_result(zz_element_t got);
			zz_element_t exp_e;
			if (pending_elements.size() == 0) begin
				$display("%0t: result with nothing outstanding, actual value %h row %0d col %0d",
					$time, got.value, got.row, got.col);
				errors++;
			end else begin
				exp_e = pending_elements.pop_front();
				if (got.value !== exp_e.value) begin
					$display("%0t: out_value mismatch, expected %h, actual %h",
						$time, exp_e.value, got.value);
					errors++;
				end
				if (got.row !== exp_e.row) begin
					$display("%0t: out_row mismatch, expected %0d, actual %0d",
						$time, exp_e.row, got.row);
					errors++;
				end
				if (got.col !== exp_e.col) begin
					$display("%0t: out_col mismatch, expected %0d, actual %0d",
						$time, exp_e.col, got.col);
					errors++;
				end
				if (got.last !== exp_e.last) begin
					$display("%0t: is_last mismatch, expected %b, actual %b",
						$time, exp_e.last, got.last);
					errors++;
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;

	zsr_req_if #(.DATA_BITS(DEF_DATA_BITS)) req_ch ();
	zsr_rsp_if #(.DATA_BITS(DEF_DATA_BITS)) rsp_ch ();

	zigzag_scan_reorder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	zigzag_scan_tracker sb;
	int  send_idle_pct = 27;
	int  recv_idle_pct = 59;
	int  items_sent    = 0;
	int  cycles        = 0;
	int  phase_sizes [NUM_PHASES] = '{8, 4, 3, 64, 5, 127, 7, 1, 6, 2, 0, 65, 8, 3};

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_result({rsp_ch.out_value, rsp_ch.out_row, rsp_ch.out_col, rsp_ch.is_last});
	end

	function automatic logic [15:0] pick_value();
		logic [15:0] v;
		v = 16'($urandom);
		case ($urandom_range(7))
			0: v = 16'h0000;
			1: v = 16'hFFFF;
			default: ;
		endcase
		return v;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic push_request(input logic kind, input logic [15:0] value);
		if (items_sent >= 2*TOTAL_ITEMS/3) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end else if (items_sent >= TOTAL_ITEMS/3) begin
			send_idle_pct = 59;
			recv_idle_pct = 27;
		end
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= kind;
		req_ch.element_value <= value;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		sb.note_request(kind, value);
		items_sent++;
		@(negedge clk);
	endtask

	// hold the request channel until every read has been answered
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_size(input logic [6:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_size(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [6:0] size_code);
		int n;
		int read_pct;
		write_size(size_code);
		n = sb.side();
		read_pct = (n > 8) ? 30 : 50;
		// for sides up to 8, load a whole matrix first so the walk can run freely
		if (n <= 8) begin
			for (int i = 0; i < n*n; i++)
				push_request(REQ_WRITE, pick_value());
		end
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if ($urandom_range(99) < read_pct && sb.can_read())
				push_request(REQ_READ, 16'($urandom));
			else
				push_request(REQ_WRITE, pick_value());
			if ($urandom_range(149) == 0)
				wait_drained();
		end
	endtask

	initial begin
		sb = new();
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_WRITE;
		req_ch.element_value = '0;
		rsp_ch.ready         = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// side length out of reset
		push_request(REQ_WRITE, 16'hA5A5);
		push_request(REQ_READ, 16'h0000);

		// two by two: load wrap, scan wrap, size write in mid walk
		write_size(7'd2);
		push_request(REQ_WRITE, 16'h0000);
		push_request(REQ_WRITE, 16'hFFFF);
		push_request(REQ_WRITE, 16'h5555);
		push_request(REQ_WRITE, 16'hAAAA);
		repeat (5) push_request(REQ_READ, 16'hFFFF);
		push_request(REQ_WRITE, 16'h8001);
		push_request(REQ_READ, 16'h0000);

		// one by one, and the size codes that saturate
		write_size(7'd1);
		push_request(REQ_WRITE, 16'h1234);
		push_request(REQ_READ, 16'h0000);
		push_request(REQ_READ, 16'h0000);
		write_size(7'd0);
		push_request(REQ_WRITE, 16'h0001);
		push_request(REQ_READ, 16'h0000);
		write_size(7'd127);
		push_request(REQ_WRITE, 16'hFFFF);
		push_request(REQ_READ, 16'h0000);

		for (int p = 0; p < NUM_PHASES; p++)
			run_phase(phase_sizes[p][6:0]);

		wait_drained();
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/zsr_pkg.sv
sv/zsr_if.sv
sv/zsr_walk.sv
sv/zsr_mem.sv
sv/zigzag_scan_reorder_top.sv
bench/tb_zigzag_scan_reorder_top.sv
